[src/bplc_pkg.sv]
// Shared types and constants for the button press length classifier.
// Depends on nothing; the interface file and the top level import it.
package bplc_pkg;

  // Press class as it appears on the result beat.
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_SHORT = 2'd1,
    CLS_LONG  = 2'd2,
    CLS_VLONG = 2'd3
  } class_e;

  // Press phase state machine, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SHORT = 4'b0010,
    PH_LONG  = 4'b0100,
    PH_VLONG = 4'b1000
  } phase_e;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned RegIdxW = 2;
  localparam int unsigned PaddrW  = RegIdxW + 2;
  localparam logic [RegIdxW-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [RegIdxW-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [RegIdxW-1:0] REG_VLONG      = 2'd2;

  localparam int unsigned DebounceW = 16;
  localparam int unsigned HoldW     = 32;

  localparam logic [DebounceW-1:0] DebounceReset  = 16'd5;
  localparam logic [HoldW-1:0]     LongPressReset = 32'd1000;
  localparam logic [HoldW-1:0]     VlongReset     = 32'd3000;

  // Class code of a phase; the class of an idle button is none.
  function automatic class_e phase_to_class(phase_e ph);
    class_e cls;
    case (ph)
      PH_SHORT: cls = CLS_SHORT;
      PH_LONG:  cls = CLS_LONG;
      PH_VLONG: cls = CLS_VLONG;
      default:  cls = CLS_NONE;
    endcase
    return cls;
  endfunction

endpackage

[src/bplc_if.sv]
// Valid/ready channel interfaces for the button press length classifier.
// Depends on bplc_pkg for the press class type.
interface bplc_in_if;
  logic valid;
  logic ready;
  logic button_active;
  logic take_result;

  modport source (output valid, output button_active, output take_result, input ready);
  modport sink (input valid, input button_active, input take_result, output ready);
endinterface

interface bplc_out_if;
  import bplc_pkg::*;
  logic   valid;
  logic   ready;
  class_e taken_class;
  class_e current_class;

  modport source (output valid, output taken_class, output current_class, input ready);
  modport sink (input valid, input taken_class, input current_class, output ready);
endinterface

[src/button_press_length_classifier.sv]
// Top level of the button press length classifier: debounce, hold timing and
// the pending class slot. Depends on bplc_pkg and the interfaces in bplc_if.sv.
//
//   channel  direction  carries
//   in_i     sink       button_active, take_result (one sampled tick per beat)
//   out_o    source     taken_class, current_class (one beat per input beat)
//   APB      slave      debounce_ticks, long_press_ticks, very_long_press_ticks
//
// Every input beat is processed in the cycle it is accepted, and its result is
// held in a single output register, so one beat per cycle flows through unless
// the output stalls. The input is ready whenever the output register is
// empty or is being emptied in the same cycle; a stall at the output therefore
// stalls the input for exactly as long. Reset is asynchronous and active low;
// it returns the press phase to idle, clears both counts and the pending class
// and loads the register defaults.
module button_press_length_classifier
  import bplc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  bplc_in_if.sink           in_i,
  bplc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [DebounceW-1:0] debounce_ticks_q;
  logic [HoldW-1:0]     long_ticks_q;
  logic [HoldW-1:0]     vlong_ticks_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= DebounceReset;
      long_ticks_q     <= LongPressReset;
      vlong_ticks_q    <= VlongReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DEBOUNCE:   debounce_ticks_q <= pwdata[DebounceW-1:0];
        REG_LONG_PRESS: long_ticks_q     <= pwdata[HoldW-1:0];
        REG_VLONG:      vlong_ticks_q    <= pwdata[HoldW-1:0];
        default: ; // Writes outside the register map are dropped.
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE:   prdata = {{(32-DebounceW){1'b0}}, debounce_ticks_q};
      REG_LONG_PRESS: prdata = long_ticks_q;
      REG_VLONG:      prdata = vlong_ticks_q;
      default:        prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Press state
  // ------------------------------------------------------------------
  phase_e               phase_q, phase_d;
  logic [DebounceW-1:0] deb_cnt_q, deb_cnt_d;
  logic [HoldW-1:0]     hold_cnt_q, hold_cnt_d;
  class_e               pending_q, pending_d;

  logic                 out_valid_q;
  class_e               taken_q, current_q;

  logic                 in_accept;
  logic [DebounceW-1:0] deb_bumped;
  logic [HoldW-1:0]     hold_bumped;
  logic                 deb_passed;
  class_e               taken_d;

  // The output register frees up in the same cycle it is read, so the input
  // side keeps flowing while the consumer keeps up.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Both counts saturate instead of wrapping.
  assign deb_bumped  = (deb_cnt_q == '1) ? deb_cnt_q : deb_cnt_q + 1'b1;
  assign hold_bumped = (hold_cnt_q == '1) ? hold_cnt_q : hold_cnt_q + 1'b1;
  assign deb_passed  = deb_bumped > debounce_ticks_q;

  always_comb begin
    phase_d    = phase_q;
    deb_cnt_d  = deb_cnt_q;
    hold_cnt_d = hold_cnt_q;
    pending_d  = pending_q;
    taken_d    = CLS_NONE;

    // A take sees the pending class as it stood before this tick; a release
    // in the same tick then refills the slot, so nothing is lost.
    if (in_i.take_result) begin
      taken_d   = pending_q;
      pending_d = CLS_NONE;
    end

    if (phase_q == PH_IDLE) begin
      if (in_i.button_active) begin
        deb_cnt_d = deb_bumped;
        if (deb_passed) begin
          phase_d    = PH_SHORT;
          deb_cnt_d  = '0;
          hold_cnt_d = '0;
        end
      end else begin
        // Released while idle: any bounce towards pressed is forgotten.
        deb_cnt_d = '0;
      end
    end else begin
      hold_cnt_d = hold_bumped;
      if (!in_i.button_active) begin
        deb_cnt_d = deb_bumped;
        if (deb_passed) begin
          pending_d  = phase_to_class(phase_q);
          phase_d    = PH_IDLE;
          deb_cnt_d  = '0;
          hold_cnt_d = '0;
        end
      end else begin
        deb_cnt_d = '0;
        // The class climbs at most one step per tick.
        if (phase_q == PH_SHORT && hold_bumped > long_ticks_q) begin
          phase_d = PH_LONG;
        end else if (phase_q == PH_LONG && hold_bumped > vlong_ticks_q) begin
          phase_d = PH_VLONG;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      deb_cnt_q  <= '0;
      hold_cnt_q <= '0;
      pending_q  <= CLS_NONE;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      deb_cnt_q  <= deb_cnt_d;
      hold_cnt_q <= hold_cnt_d;
      pending_q  <= pending_d;
    end
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      taken_q   <= taken_d;
      current_q <= phase_to_class(phase_d);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.taken_class   = taken_q;
  assign out_o.current_class = current_q;

endmodule
